### rtl/core/tkp_pkg.sv
// Shared types and constants for the top-k pair store.
// Holds the cell record, the row command and status structs and the op codes.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package tkp_pkg;

  // Sizing
  localparam int DEPTH     = 64;   // number of cells in the row
  localparam int NODE_BITS = 16;   // significant node index bits
  localparam int PORT_NODE_W = 16; // node field width on the ports
  localparam int NODE_W    = (NODE_BITS < PORT_NODE_W) ? NODE_BITS : PORT_NODE_W;
  localparam int SCORE_W   = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int PFX_LVL   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_W     = 7;
  localparam int HELD_W    = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Request op codes
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // Row command codes
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_POP,
    CMD_COMPACT,
    CMD_CLEAR
  } cmd_code_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PURGE,
    S_DONE
  } state_t;

  // One stored entry
  typedef struct packed {
    logic                      used;
    logic                      sent;
    logic [NODE_W-1:0]         a;
    logic [NODE_W-1:0]         b;
    logic signed [SCORE_W-1:0] score;
  } cell_t;

  // Broadcast command to every cell
  typedef struct packed {
    cmd_code_t                 code;
    logic [NODE_W-1:0]         key_a;
    logic [NODE_W-1:0]         key_b;
    logic signed [SCORE_W-1:0] key_score;
    logic [CNT_W-1:0]          limit;
  } cmd_t;

  // Status the row reports back to the controller
  typedef struct packed {
    cell_t head;
    logic  any_hit;
    logic  any_less;
  } row_stat_t;

endpackage

### rtl/core/top_k_pair_store_with_conflict_purge.sv
// Top level of the top-k pair store with conflict purge.
// Holds the request controller, capacity register and result register.
// Depends on tkp_pkg and tkp_row.
`timescale 1ns / 1ps

// The store keeps scored node pairs in a row of cells, best at the head, and
// starts out (and after clear) with one sentinel ranked below every score.
// Insert keeps a pair only if the store is empty or the score beats the
// current minimum, then trims the store to the capacity register (capped at
// the cell count); extract hands back the best pair, newest among ties, and
// then removes every stored pair that shares a node with it. Requests are
// taken one at a time: insert, clear, the unused op and an extract that finds
// only the sentinel or an empty store pass from S_EXEC straight to S_DONE
// (sort-and-shift happens in a single row command); an extract that
// returns a real pair passes through S_PURGE, where the row squeezes out one
// conflicting cell per cycle until none is left. A finished result sits
// in the output register while the next request is accepted. Capacity
// writes take effect on the next insert; there is no clearing pass after
// reset.
module top_k_pair_store_with_conflict_purge (
  input  logic                    clk,
  input  logic                    rst_n,
  // request channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_op,
  input  logic [15:0]             in_node_a,
  input  logic [15:0]             in_node_b,
  input  logic signed [31:0]      in_score,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_found,
  output logic [15:0]             out_best_a,
  output logic [15:0]             out_best_b,
  output logic signed [31:0]      out_best_score,
  output logic                    out_is_empty,
  output logic [6:0]              out_held_count,
  // configuration
  input  logic                    cfg_we,
  input  logic [6:0]              cfg_wdata
);
  import tkp_pkg::*;

  state_t                    state_r, state_nxt;
  logic [1:0]                op_r, op_nxt;
  logic [NODE_W-1:0]         a_r, a_nxt;
  logic [NODE_W-1:0]         b_r, b_nxt;
  logic signed [SCORE_W-1:0] score_r, score_nxt;
  logic                      found_r, found_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [CAP_W-1:0]          cap_r;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_found_r, out_found_nxt;
  logic [15:0]               out_best_a_r, out_best_a_nxt;
  logic [15:0]               out_best_b_r, out_best_b_nxt;
  logic signed [31:0]        out_best_score_r, out_best_score_nxt;
  logic                      out_is_empty_r, out_is_empty_nxt;
  logic [HELD_W-1:0]         out_held_r, out_held_nxt;

  cmd_t                      cmd;
  row_stat_t                 stat;
  logic [CNT_W-1:0]          lim;
  logic [CNT_W-1:0]          ins_cnt;
  logic [CNT_W-1:0]          grown_cnt;
  logic                      reject;

  // Cell row
  tkp_row u_row (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Capacity limit and post-insert count
  always_comb begin
    lim       = (int'(cap_r) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(cap_r);
    grown_cnt = (count_r == CNT_W'(DEPTH)) ? count_r : count_r + 1'b1;
    ins_cnt   = (grown_cnt > lim) ? lim : grown_cnt;
    reject    = (count_r != '0) && !stat.any_less;
  end

  assign in_ready = (state_r == S_IDLE);

  // Controller: next state, row command and result register
  always_comb begin
    state_nxt          = state_r;
    op_nxt             = op_r;
    a_nxt              = a_r;
    b_nxt              = b_r;
    score_nxt          = score_r;
    found_nxt          = found_r;
    count_nxt          = count_r;
    cmd.code           = CMD_HOLD;
    cmd.key_a          = a_r;
    cmd.key_b          = b_r;
    cmd.key_score      = score_r;
    cmd.limit          = lim;
    out_valid_nxt      = out_valid_r && !out_ready;
    out_found_nxt      = out_found_r;
    out_best_a_nxt     = out_best_a_r;
    out_best_b_nxt     = out_best_b_r;
    out_best_score_nxt = out_best_score_r;
    out_is_empty_nxt   = out_is_empty_r;
    out_held_nxt       = out_held_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          a_nxt     = NODE_W'(in_node_a);
          b_nxt     = NODE_W'(in_node_b);
          score_nxt = in_score;
          found_nxt = 1'b0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        unique case (op_r)
          OP_INSERT: begin
            if (!reject) begin
              cmd.code  = CMD_INSERT;
              count_nxt = ins_cnt;
            end
          end
          OP_EXTRACT: begin
            // pop the head; a real pair becomes the purge key
            if (count_r != '0) begin
              cmd.code  = CMD_POP;
              count_nxt = count_r - 1'b1;
              a_nxt     = stat.head.a;
              b_nxt     = stat.head.b;
              score_nxt = stat.head.score;
              found_nxt = !stat.head.sent;
              if (!stat.head.sent) begin
                state_nxt = S_PURGE;
              end
            end
          end
          OP_CLEAR: begin
            cmd.code  = CMD_CLEAR;
            count_nxt = CNT_W'(1);
          end
          default: begin
            cmd.code = CMD_HOLD;
          end
        endcase
      end
      S_PURGE: begin
        // squeeze out the lowest conflicting cell each cycle
        if (stat.any_hit) begin
          cmd.code  = CMD_COMPACT;
          count_nxt = count_r - 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_found_nxt      = found_r;
          out_best_a_nxt     = found_r ? 16'(a_r) : 16'd0;
          out_best_b_nxt     = found_r ? 16'(b_r) : 16'd0;
          out_best_score_nxt = found_r ? score_r : 32'sd0;
          out_is_empty_nxt   = (count_r == '0) ||
                               ((count_r == CNT_W'(1)) && stat.head.sent);
          out_held_nxt       = HELD_W'(count_r);
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CNT_W'(1);
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    op_r             <= op_nxt;
    a_r              <= a_nxt;
    b_r              <= b_nxt;
    score_r          <= score_nxt;
    found_r          <= found_nxt;
    out_found_r      <= out_found_nxt;
    out_best_a_r     <= out_best_a_nxt;
    out_best_b_r     <= out_best_b_nxt;
    out_best_score_r <= out_best_score_nxt;
    out_is_empty_r   <= out_is_empty_nxt;
    out_held_r       <= out_held_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_best_a     = out_best_a_r;
  assign out_best_b     = out_best_b_r;
  assign out_best_score = out_best_score_r;
  assign out_is_empty   = out_is_empty_r;
  assign out_held_count = out_held_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above cell count");

  a_head_used: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) == stat.head.used)
    else $error("head cell occupancy disagrees with entry count");

  a_clear_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) && (op_r == OP_CLEAR)
    |=> (count_r == CNT_W'(1)) && stat.head.sent && stat.head.used)
    else $error("clear did not leave the lone sentinel");

  a_purge_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PURGE) && !stat.any_hit |=> (state_r == S_DONE))
    else $error("purge did not finish when no conflict remained");

  a_purge_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PURGE) && stat.any_hit |=> (count_r == $past(count_r) - 1'b1))
    else $error("purge step did not drop one entry");

endmodule

### rtl/core/tkp_cell.sv
// One cell of the pair store row: holds one entry and steps it per command.
// Takes neighbor entries from the cells below and above it.
// Depends on tkp_pkg.
`timescale 1ns / 1ps

module tkp_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  tkp_pkg::cmd_t cmd,
  input  tkp_pkg::cell_t lo_cell,
  input  logic          lo_g,
  input  tkp_pkg::cell_t hi_cell,
  input  logic          shift_dn,
  input  logic          is_head,
  input  logic          in_lim,
  output tkp_pkg::cell_t cell_q,
  output logic          g,
  output logic          less,
  output logic          hit
);
  import tkp_pkg::*;

  logic                      used_r, used_nxt;
  logic                      sent_r, sent_nxt;
  logic [NODE_W-1:0]         a_r, a_nxt;
  logic [NODE_W-1:0]         b_r, b_nxt;
  logic signed [SCORE_W-1:0] score_r, score_nxt;
  cell_t                     cur;
  cell_t                     nxt;

  assign cur    = '{used: used_r, sent: sent_r, a: a_r, b: b_r, score: score_r};
  assign cell_q = cur;

  // Local compares: insert position, rejection test and purge match
  always_comb begin
    g    = !used_r || sent_r || (score_r <= cmd.key_score);
    less = used_r && (sent_r || (score_r < cmd.key_score));
    hit  = used_r && !sent_r &&
           ((a_r == cmd.key_a) || (b_r == cmd.key_a) ||
            (a_r == cmd.key_b) || (b_r == cmd.key_b));
  end

  // Next entry per command
  always_comb begin
    nxt = cur;
    unique case (cmd.code)
      CMD_HOLD: begin
        nxt = cur;
      end
      CMD_INSERT: begin
        // cells at and above the slot move up one; the slot takes the new pair
        if (lo_g) begin
          nxt = lo_cell;
        end else if (g) begin
          nxt.used  = 1'b1;
          nxt.sent  = 1'b0;
          nxt.a     = cmd.key_a;
          nxt.b     = cmd.key_b;
          nxt.score = cmd.key_score;
        end
        // evict everything beyond the capacity limit
        nxt.used = nxt.used & in_lim;
      end
      CMD_POP: begin
        nxt = hi_cell;
      end
      CMD_COMPACT: begin
        if (shift_dn) begin
          nxt = hi_cell;
        end
      end
      CMD_CLEAR: begin
        nxt.used = is_head;
        nxt.sent = is_head;
      end
      default: begin
        nxt = cur;
      end
    endcase
    used_nxt  = nxt.used;
    sent_nxt  = nxt.sent;
    a_nxt     = nxt.a;
    b_nxt     = nxt.b;
    score_nxt = nxt.score;
  end

  // Flags: only the head cell holds the sentinel after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= is_head;
      sent_r <= is_head;
    end else begin
      used_r <= used_nxt;
      sent_r <= sent_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    score_r <= score_nxt;
  end

endmodule

### rtl/core/tkp_row.sv
// Row of pair store cells, best entry at cell zero, descending rank.
// Wires neighbors, builds the purge prefix and the status reductions.
// Depends on tkp_pkg and tkp_cell.
`timescale 1ns / 1ps

module tkp_row (
  input  logic               clk,
  input  logic               rst_n,
  input  tkp_pkg::cmd_t      cmd,
  output tkp_pkg::row_stat_t stat
);
  import tkp_pkg::*;

  cell_t            cells [DEPTH];
  logic [DEPTH-1:0] g_v;
  logic [DEPTH-1:0] less_v;
  logic [DEPTH-1:0] hit_v;
  logic [DEPTH-1:0] shd_v;
  logic [DEPTH-1:0] lim_v;

  // Cell chain
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    cell_t lo_c;
    cell_t hi_c;
    logic  lo_gk;

    if (k == 0) begin : g_first
      assign lo_c  = '0;
      assign lo_gk = 1'b0;
    end else begin : g_mid
      assign lo_c  = cells[k-1];
      assign lo_gk = g_v[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign hi_c = '0;
    end else begin : g_inner
      assign hi_c = cells[k+1];
    end

    assign lim_v[k] = (CNT_W'(k) < cmd.limit);

    tkp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .lo_cell  (lo_c),
      .lo_g     (lo_gk),
      .hi_cell  (hi_c),
      .shift_dn (shd_v[k]),
      .is_head  (k == 0),
      .in_lim   (lim_v[k]),
      .cell_q   (cells[k]),
      .g        (g_v[k]),
      .less     (less_v[k]),
      .hit      (hit_v[k])
    );
  end

  // Prefix OR of purge hits: a cell shifts down once any hit sits at or below it
  always_comb begin
    logic [DEPTH-1:0] acc;
    logic [DEPTH-1:0] step;
    acc = hit_v;
    for (int l = 0; l < PFX_LVL; l++) begin
      step = acc;
      for (int k = 0; k < DEPTH; k++) begin
        if (k >= (1 << l)) begin
          step[k] = acc[k] | acc[k - (1 << l)];
        end
      end
      acc = step;
    end
    shd_v = acc;
  end

  // Status
  assign stat.head     = cells[0];
  assign stat.any_hit  = |hit_v;
  assign stat.any_less = |less_v;

endmodule
